// ----- rtl/bspa_pkg.sv -----
// ----------------------------------------------------------------------------
// bspa_pkg
// Shared types and constants of the bar strategy gain accumulator.
// ----------------------------------------------------------------------------
package bspa_pkg;

  // Field widths fixed by the bar and result formats
  localparam int unsigned PriceW   = 32;
  localparam int unsigned GainW    = PriceW + 1;
  localparam int unsigned TotalW   = 64;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned WinLenW  = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [WinLenW-1:0] WindowLenReset = WinLenW'(5);

  // Strategy rule codes
  typedef enum logic [ModeW-1:0] {
    MODE_MOMENTUM = 2'd0,
    MODE_BREAKOUT = 2'd1,
    MODE_SMA      = 2'd2
  } strat_mode_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_STRATEGY_MODE = 2'd0,
    REG_WINDOW_LENGTH = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [PriceW-1:0] bar_high;
    logic [PriceW-1:0] bar_close;
    logic              series_start;
  } bar_in_t;

  typedef struct packed {
    logic signed [GainW-1:0]  bar_gain;
    logic signed [TotalW-1:0] total_gain;
    logic                     gain_valid;
  } bar_out_t;

  // Ring update strobes
  typedef struct packed {
    logic push;
    logic clear;
  } win_ctrl_t;

endpackage

// ----- rtl/bspa_ram.sv -----
// ----------------------------------------------------------------------------
// bspa_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bspa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/bspa_window.sv -----
// ----------------------------------------------------------------------------
// bspa_window
// Ring of recent closes with running sum, fill count and write position.
// ----------------------------------------------------------------------------
module bspa_window #(
  parameter int unsigned MaxWindow = 64
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  bspa_pkg::win_ctrl_t                      ctrl_i,
  input  logic [$clog2(MaxWindow+1)-1:0]           win_i,
  input  logic [bspa_pkg::PriceW-1:0]              close_i,
  output logic                                     full_o,
  output logic [bspa_pkg::PriceW+$clog2(MaxWindow)-1:0] sum_o
);
  import bspa_pkg::*;

  localparam int unsigned CntW = $clog2(MaxWindow + 1);
  localparam int unsigned PosW = $clog2(MaxWindow);
  localparam int unsigned SumW = PriceW + $clog2(MaxWindow);

  logic [PosW-1:0]   pos_q, pos_d;
  logic [CntW-1:0]   cnt_q, cnt_new;
  logic [SumW-1:0]   sum_q, sum_new;
  logic [CntW-1:0]   pos_inc;
  logic [PriceW-1:0] rdata, oldest;
  logic              byp_q, byp_d;
  logic [PriceW-1:0] byp_data_q;
  logic              was_full;

  // Oldest close: RAM output, or the close written at the slot just read
  assign oldest   = byp_q ? byp_data_q : rdata;
  assign was_full = (cnt_q >= win_i);

  // Replace the oldest close once the window is full, else grow
  always_comb begin
    if (was_full) begin
      sum_new = sum_q - SumW'(oldest) + SumW'(close_i);
      cnt_new = cnt_q;
    end else begin
      sum_new = sum_q + SumW'(close_i);
      cnt_new = cnt_q + CntW'(1);
    end
  end

  assign full_o = (cnt_new >= win_i);
  assign sum_o  = sum_new;

  // Advance the write slot, wrapping at the window length
  assign pos_inc = CntW'(pos_q) + CntW'(1);

  always_comb begin
    pos_d = pos_q;
    if (ctrl_i.clear) begin
      pos_d = '0;
    end else if (ctrl_i.push) begin
      pos_d = (pos_inc == win_i) ? '0 : PosW'(pos_inc);
    end
  end

  // Forward the write when the next read hits the same slot
  assign byp_d = ctrl_i.push && (pos_q == pos_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cnt_q <= '0;
      sum_q <= '0;
      byp_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      byp_q <= byp_d;
      if (ctrl_i.clear) begin
        cnt_q <= '0;
        sum_q <= '0;
      end else if (ctrl_i.push) begin
        cnt_q <= cnt_new;
        sum_q <= sum_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= close_i;
  end

  // Read ahead at the next slot so its oldest close is ready for the next item
  bspa_ram #(
    .Width (PriceW),
    .Depth (MaxWindow)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.push),
    .waddr_i (pos_q),
    .wdata_i (close_i),
    .raddr_i (pos_d),
    .rdata_o (rdata)
  );

endmodule

// ----- rtl/bspa_gain.sv -----
// ----------------------------------------------------------------------------
// bspa_gain
// Strategy rule selection and saturating update of the running total.
// ----------------------------------------------------------------------------
module bspa_gain #(
  parameter int unsigned MaxWindow = 64
) (
  input  logic [bspa_pkg::ModeW-1:0]                    mode_i,
  input  logic                                          first_i,
  input  logic [bspa_pkg::PriceW-1:0]                   close_i,
  input  logic [bspa_pkg::PriceW-1:0]                   high_i,
  input  logic [bspa_pkg::PriceW-1:0]                   prev_close_i,
  input  logic [bspa_pkg::PriceW-1:0]                   prev_high_i,
  input  logic                                          full_i,
  input  logic [bspa_pkg::PriceW+$clog2(MaxWindow)-1:0] sum_i,
  input  logic [$clog2(MaxWindow+1)-1:0]                win_i,
  input  logic signed [bspa_pkg::TotalW-1:0]            total_i,
  output logic signed [bspa_pkg::GainW-1:0]             gain_o,
  output logic signed [bspa_pkg::TotalW-1:0]            total_o
);
  import bspa_pkg::*;

  localparam int unsigned WinW  = $clog2(MaxWindow + 1);
  localparam int unsigned SumW  = PriceW + $clog2(MaxWindow);
  localparam int unsigned ProdW = PriceW + WinW;
  localparam int unsigned CmpW  = (ProdW > SumW) ? ProdW : SumW;

  localparam logic signed [TotalW-1:0] TotalMax = {1'b0, {(TotalW-1){1'b1}}};
  localparam logic signed [TotalW-1:0] TotalMin = {1'b1, {(TotalW-1){1'b0}}};

  logic [ProdW-1:0]        prod;
  logic                    above_mean;
  logic signed [GainW-1:0] d_close, d_high, gain;
  logic signed [TotalW:0]  acc;

  // Exact mean test: close * window > sum
  assign prod       = ProdW'(close_i) * ProdW'(win_i);
  assign above_mean = CmpW'(prod) > CmpW'(sum_i);

  assign d_close = $signed({1'b0, close_i}) - $signed({1'b0, prev_close_i});
  assign d_high  = $signed({1'b0, close_i}) - $signed({1'b0, prev_high_i});

  // Pick the credited gain by rule
  always_comb begin
    gain = '0;
    case (mode_i)
      MODE_MOMENTUM: if (close_i > prev_close_i) gain = d_close;
      MODE_BREAKOUT: if (high_i > prev_high_i) gain = d_high;
      MODE_SMA:      if (full_i && above_mean) gain = d_close;
      default:       gain = '0;
    endcase
  end

  // Saturating add into the total
  assign acc = {total_i[TotalW-1], total_i} + (TotalW+1)'(gain);

  always_comb begin
    if (first_i) begin
      gain_o  = '0;
      total_o = '0;
    end else begin
      gain_o = gain;
      if (acc[TotalW] != acc[TotalW-1]) begin
        total_o = acc[TotalW] ? TotalMin : TotalMax;
      end else begin
        total_o = acc[TotalW-1:0];
      end
    end
  end

endmodule

// ----- rtl/bar_strategy_pnl_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// bar_strategy_pnl_accumulator_core
// Bar-by-bar strategy gain accumulator with a saturating running total.
// ----------------------------------------------------------------------------
// Takes one price bar per cycle while the output side is not stalled and
// returns one result item per bar, in order. An accepted bar is held in the
// input register until the output register is free or being drained, is then
// evaluated, and its result is loaded into the output register to wait there
// until taken. The recent closes for the moving average rule live in a
// MAX_WINDOW-deep RAM with one write and one registered read port; the read
// address always points at the next slot to be overwritten, so the oldest
// close is ready when the next bar is evaluated and the block sustains one bar
// per cycle unless the output side stalls. The RAM needs no clearing after
// reset. The configuration port is always ready; write it only while no bar is
// in flight. Writing window_length empties the ring but keeps the total.
// ----------------------------------------------------------------------------
module bar_strategy_pnl_accumulator_core #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bspa_pkg::bar_in_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bspa_pkg::bar_out_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bspa_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bspa_pkg::CfgDataW-1:0] cfg_data_i
);
  import bspa_pkg::*;

  localparam int unsigned WinW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SumW = PriceW + $clog2(MAX_WINDOW);

  logic [ModeW-1:0]   mode_q;
  logic [WinLenW-1:0] win_len_q;
  logic [WinW-1:0]    win_eff;
  logic               cfg_we, win_write;

  logic               in_valid_q;
  bar_in_t            in_q;
  logic               out_valid_q;
  bar_out_t           out_q, out_d;
  logic               adv, first;

  logic               have_prev_q;
  logic [PriceW-1:0]  prev_close_q, prev_high_q;
  logic signed [TotalW-1:0] total_q, total_new;
  logic signed [GainW-1:0]  gain;

  win_ctrl_t          win_ctrl;
  logic               win_full;
  logic [SumW-1:0]    win_sum;

  // Configuration writes
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign win_write   = cfg_we && (cfg_index_i == REG_WINDOW_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_MOMENTUM;
      win_len_q <= WindowLenReset;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_STRATEGY_MODE: mode_q    <= cfg_data_i[ModeW-1:0];
        REG_WINDOW_LENGTH: win_len_q <= cfg_data_i[WinLenW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the window length into 1..MAX_WINDOW
  always_comb begin
    if (win_len_q == '0) begin
      win_eff = WinW'(1);
    end else if (32'(win_len_q) > 32'(MAX_WINDOW)) begin
      win_eff = WinW'(MAX_WINDOW);
    end else begin
      win_eff = WinW'(win_len_q);
    end
  end

  // Handshake: evaluate when the output register is free or being drained
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;
  assign first      = in_q.series_start || !have_prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Ring strobes: first bars and window writes empty it, others push
  assign win_ctrl.push  = adv && !first;
  assign win_ctrl.clear = (adv && first) || win_write;

  bspa_window #(
    .MaxWindow (MAX_WINDOW)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (win_ctrl),
    .win_i   (win_eff),
    .close_i (in_q.bar_close),
    .full_o  (win_full),
    .sum_o   (win_sum)
  );

  bspa_gain #(
    .MaxWindow (MAX_WINDOW)
  ) u_gain (
    .mode_i       (mode_q),
    .first_i      (first),
    .close_i      (in_q.bar_close),
    .high_i       (in_q.bar_high),
    .prev_close_i (prev_close_q),
    .prev_high_i  (prev_high_q),
    .full_i       (win_full),
    .sum_i        (win_sum),
    .win_i        (win_eff),
    .total_i      (total_q),
    .gain_o       (gain),
    .total_o      (total_new)
  );

  // Previous bar and running total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q  <= 1'b0;
      prev_close_q <= '0;
      prev_high_q  <= '0;
      total_q      <= '0;
    end else if (adv) begin
      have_prev_q  <= 1'b1;
      prev_close_q <= in_q.bar_close;
      prev_high_q  <= in_q.bar_high;
      total_q      <= total_new;
    end
  end

  // Result register
  always_comb begin
    out_d.bar_gain   = gain;
    out_d.total_gain = total_new;
    out_d.gain_valid = !first;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bar strategy gain accumulator.
// ----------------------------------------------------------------------------
// Bars go in over a valid/ready channel. A predictor inside the bench keeps
// its own copy of the previous bar, the close ring, the window sum and the
// running total. It queues one expected result per accepted bar, and a
// monitor compares each result item with the oldest entry, field by field.
// Directed tests cover the first bar of a series, each strategy rule (with
// price extremes for momentum and breakout), window changes and out-of-range
// window values, the unused mode and the unused register indexes. Random
// series follow, with random settings, gaps on the input, stalls on the output
// and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
  import bspa_pkg::*;

  localparam int unsigned RING_DEPTH  = 64;
  localparam int unsigned RING_IDX_W  = $clog2(RING_DEPTH);
  localparam int unsigned CYCLE_LIMIT = 500000;

  // Codes the package leaves unnamed
  localparam logic [ModeW-1:0]   MODE_UNUSED = 2'd3;
  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 2'd3;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i;
  logic                in_ready_o;
  bar_in_t             in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  bar_out_t            out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Predictor state
  logic [ModeW-1:0]   strat_mode = MODE_MOMENTUM;
  logic [WinLenW-1:0] win_len    = WindowLenReset;
  logic [PriceW-1:0]  last_close = '0;
  logic [PriceW-1:0]  last_high  = '0;
  logic               seen_bar   = 1'b0;
  logic [PriceW-1:0]  closes [RING_DEPTH];
  int unsigned        slot       = 0;
  int unsigned        fill       = 0;
  logic [63:0]        close_sum  = '0;
  logic [TotalW-1:0]  pnl_total  = '0;

  bar_out_t    expected_q [$];
  bar_out_t    want;
  int unsigned err_cnt           = 0;
  int unsigned cycle_cnt         = 0;
  bit          tx_gaps_on        = 1'b1;
  bit          rx_stalls_on      = 1'b1;
  int unsigned ready_hold_cycles = 0;
  int unsigned stall_left        = 0;
  logic [PriceW-1:0] tx_close    = '0;

  bar_strategy_pnl_accumulator_core #(
    .MAX_WINDOW (RING_DEPTH)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned active_window();
    if (win_len == '0) return 1;
    if (32'(win_len) > RING_DEPTH) return RING_DEPTH;
    return 32'(win_len);
  endfunction

  function automatic void empty_ring();
    slot      = 0;
    fill      = 0;
    close_sum = '0;
  endfunction

  function automatic bar_out_t predict_bar(input bar_in_t bar);
    bar_out_t res;
    longint gain;
    int unsigned w;
    int unsigned pos;
    logic signed [TotalW:0] wide;
    gain = 0;
    res.gain_valid = 1'b1;
    if (bar.series_start || !seen_bar) begin
      // first bar of a series: restart history and total
      empty_ring();
      pnl_total = '0;
      res.gain_valid = 1'b0;
    end else begin
      // push the close, dropping the oldest once the window is full
      w   = active_window();
      pos = slot % w;
      if (fill >= w) close_sum = close_sum - 64'(closes[RING_IDX_W'(pos)]);
      else fill++;
      closes[RING_IDX_W'(pos)] = bar.bar_close;
      close_sum   = close_sum + 64'(bar.bar_close);
      slot        = (pos + 1) % w;
      case (strat_mode)
        MODE_MOMENTUM: begin
          if (bar.bar_close > last_close)
            gain = $signed({32'd0, bar.bar_close}) - $signed({32'd0, last_close});
        end
        MODE_BREAKOUT: begin
          if (bar.bar_high > last_high)
            gain = $signed({32'd0, bar.bar_close}) - $signed({32'd0, last_high});
        end
        MODE_SMA: begin
          if (fill >= w && 64'(bar.bar_close) * 64'(w) > close_sum)
            gain = $signed({32'd0, bar.bar_close}) - $signed({32'd0, last_close});
        end
        default: gain = 0;
      endcase
      // saturate the total at the signed 64-bit limits
      wide = $signed({pnl_total[TotalW-1], pnl_total}) + $signed({gain[63], gain});
      if (wide[TotalW] != wide[TotalW-1])
        pnl_total = wide[TotalW] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      else
        pnl_total = wide[TotalW-1:0];
    end
    last_close = bar.bar_close;
    last_high  = bar.bar_high;
    seen_bar   = 1'b1;
    res.bar_gain   = gain[GainW-1:0];
    res.total_gain = pnl_total;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [ModeW-1:0] pick_mode();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return MODE_MOMENTUM;
    if (r < 6) return MODE_BREAKOUT;
    if (r < 9) return MODE_SMA;
    return MODE_UNUSED;
  endfunction

  function automatic logic [CfgDataW-1:0] pick_window();
    int unsigned r;
    logic [CfgDataW-1:0] data;
    r    = $urandom_range(0, 99);
    data = CfgDataW'($urandom());
    if (r < 40) data[WinLenW-1:0] = WinLenW'($urandom_range(1, 8));
    else if (r < 60) data[WinLenW-1:0] = WinLenW'($urandom_range(9, RING_DEPTH - 1));
    else if (r < 75) data[WinLenW-1:0] = WinLenW'(RING_DEPTH);
    else if (r < 85) data[WinLenW-1:0] = '0;
    else data[WinLenW-1:0] = WinLenW'($urandom_range(RING_DEPTH + 1, 127));
    return data;
  endfunction

  // Mostly a small walk around the base, sometimes a jump or an extreme
  function automatic logic [PriceW-1:0] walk_price(input logic [PriceW-1:0] base);
    logic [PriceW+1:0] p;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      p = {2'b00, base} + (PriceW+2)'($urandom_range(0, 400));
      if (p < (PriceW+2)'(200)) return '0;
      p = p - (PriceW+2)'(200);
      return p[PriceW] ? '1 : p[PriceW-1:0];
    end
    if (r < 92) return $urandom();
    return (r < 96) ? '0 : '1;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Offer one bar, queue its prediction on acceptance, then maybe idle
  task automatic send_bar(input logic [PriceW-1:0] high, input logic [PriceW-1:0] close,
                          input logic start);
    bar_in_t bar;
    bar_out_t pred;
    int unsigned gap;
    bar.bar_high     = high;
    bar.bar_close    = close;
    bar.series_start = start;
    in_data_i  <= bar;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred       = predict_bar(bar);
    expected_q = {expected_q, pred};
    @(negedge clk_i);
    gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_random_bar(input logic force_start);
    logic start;
    logic [PriceW-1:0] close;
    logic [PriceW-1:0] high;
    logic [PriceW:0] lift;
    start = force_start || ($urandom_range(0, 63) == 0);
    if (start) tx_close = $urandom();
    close = walk_price(tx_close);
    if ($urandom_range(0, 4) != 0) begin
      lift = {1'b0, close} + (PriceW+1)'($urandom_range(0, 300));
      high = lift[PriceW] ? '1 : lift[PriceW-1:0];
    end else begin
      high = walk_price(tx_close);
    end
    tx_close = close;
    send_bar(high, close, start);
  endtask

  // Hold the input low until every queued result has come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_q.size() != 0);
  endtask

  // Write one register and mirror it; valid stays up for a following write
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_STRATEGY_MODE: strat_mode = data[ModeW-1:0];
      REG_WINDOW_LENGTH: begin
        win_len = data[WinLenW-1:0];
        empty_ring();
      end
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic cfg_release();
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // First bar after reset without the flag, then a flagged restart
  task automatic test_first_bar();
    send_bar(32'd100, 32'd50, 1'b0);
    send_bar(32'd200, 32'd150, 1'b0);
    send_bar(32'd0, 32'd0, 1'b1);
  endtask

  task automatic test_momentum();
    wait_idle();
    cfg_write(REG_STRATEGY_MODE, CfgDataW'(MODE_MOMENTUM));
    cfg_release();
    send_bar('1, '1, 1'b0);
    send_bar('1, '1, 1'b0);
    send_bar('0, '0, 1'b0);
    send_bar(32'd10, 32'd7, 1'b1);
    send_bar(32'd20, 32'd9, 1'b0);
  endtask

  // Close below the old high gives a negative gain
  task automatic test_breakout();
    wait_idle();
    cfg_write(REG_STRATEGY_MODE, CfgDataW'(MODE_BREAKOUT));
    cfg_release();
    send_bar(32'd21, 32'd5, 1'b0);
    send_bar(32'd21, 32'd100, 1'b0);
    send_bar('1, '0, 1'b0);
    send_bar('0, '1, 1'b1);
    send_bar(32'd1, '1, 1'b0);
    send_bar(32'd0, 32'd3, 1'b0);
  endtask

  // Partly filled window, full window, window zero and window above the depth
  task automatic test_moving_average();
    wait_idle();
    cfg_write(REG_STRATEGY_MODE, CfgDataW'(MODE_SMA));
    cfg_write(REG_WINDOW_LENGTH, 8'h83);  // top data bit lies outside the field
    cfg_release();
    send_bar(32'd100, 32'd100, 1'b1);
    send_bar(32'd110, 32'd110, 1'b0);
    send_bar(32'd120, 32'd120, 1'b0);
    send_bar(32'd130, 32'd130, 1'b0);
    send_bar(32'd90, 32'd90, 1'b0);
    send_bar(32'd200, 32'd200, 1'b0);
    wait_idle();
    cfg_write(REG_WINDOW_LENGTH, 8'd0);
    cfg_release();
    send_bar(32'd95, 32'd95, 1'b0);
    send_bar(32'd97, 32'd96, 1'b0);
    wait_idle();
    cfg_write(REG_WINDOW_LENGTH, 8'd127);
    cfg_release();
    send_bar(32'd50, 32'd50, 1'b0);
    send_bar(32'd60, 32'd60, 1'b0);
  endtask

  // Unused mode credits nothing; spare indexes change nothing
  task automatic test_unused_settings();
    wait_idle();
    cfg_write(REG_STRATEGY_MODE, CfgDataW'(MODE_UNUSED));
    cfg_write(REG_SPARE_A, 8'hFF);
    cfg_write(REG_SPARE_B, 8'h00);
    cfg_release();
    send_bar(32'd500, 32'd400, 1'b0);
    send_bar(32'd900, 32'd800, 1'b0);
  endtask

  // Hold the output off while bars keep coming, so the input stalls
  task automatic test_backpressure();
    int unsigned k;
    wait_idle();
    cfg_write(REG_STRATEGY_MODE, CfgDataW'(MODE_MOMENTUM));
    cfg_release();
    tx_gaps_on        = 1'b0;
    ready_hold_cycles = 200;
    for (k = 0; k < 40; k++) send_random_bar(1'b0);
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_series();
    int unsigned phase;
    int unsigned n;
    int unsigned k;
    logic [CfgDataW-1:0] data;
    for (phase = 0; phase < 10; phase++) begin
      wait_idle();
      data = CfgDataW'($urandom());
      data[ModeW-1:0] = pick_mode();
      cfg_write(REG_STRATEGY_MODE, data);
      if (phase == 0) cfg_write(REG_WINDOW_LENGTH, CfgDataW'(RING_DEPTH));
      else if (phase == 1) cfg_write(REG_WINDOW_LENGTH, 8'd1);
      else if ($urandom_range(0, 1) == 0) cfg_write(REG_WINDOW_LENGTH, pick_window());
      cfg_release();
      tx_gaps_on   = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      // long enough for the window to fill
      n = 30 + active_window();
      for (k = 0; k < n; k++) send_random_bar(k == 0 && $urandom_range(0, 1) == 1);
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Output ready: random short and long stalls, plus a requested hold-off
  // ---------------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (ready_hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        stall_left = 0;
        repeat (ready_hold_cycles) @(negedge clk_i);
        ready_hold_cycles = 0;
      end else if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (rx_stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected: gain %0d total %0d valid %0b", $time,
                 out_data_o.bar_gain, out_data_o.total_gain, out_data_o.gain_valid);
        err_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (out_data_o.bar_gain !== want.bar_gain) begin
          $display("%0t: bar_gain expected %0d actual %0d", $time,
                   want.bar_gain, out_data_o.bar_gain);
          err_cnt++;
        end
        if (out_data_o.total_gain !== want.total_gain) begin
          $display("%0t: total_gain expected %0d actual %0d", $time,
                   want.total_gain, out_data_o.total_gain);
          err_cnt++;
        end
        if (out_data_o.gain_valid !== want.gain_valid) begin
          $display("%0t: gain_valid expected %0b actual %0b", $time,
                   want.gain_valid, out_data_o.gain_valid);
          err_cnt++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_first_bar();
    test_momentum();
    test_breakout();
    test_moving_average();
    test_unused_settings();
    test_backpressure();
    test_random_series();

    // drain, then give stray results time to show up
    wait_idle();
    repeat (8) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
